// File: rtl/nmd_pkg.sv
// nmd_pkg: character codes, event and sentence kind codes, header text and
// small decode helpers for the NMEA sentence deframer.
// No dependencies.
`timescale 1ns / 1ps

package nmd_pkg;

  localparam int TERM_CAPACITY = 16;
  localparam int POS_W         = $clog2(TERM_CAPACITY + 1);
  localparam int HDR_LEN       = 6;
  localparam int NUM_HDR       = 4;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] code_t;

  localparam byte_t CH_DOLLAR = 8'h24;
  localparam byte_t CH_COMMA  = 8'h2C;
  localparam byte_t CH_STAR   = 8'h2A;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_0      = 8'h30;
  localparam byte_t CH_9      = 8'h39;
  localparam byte_t CH_UA     = 8'h41;
  localparam byte_t CH_UF     = 8'h46;
  localparam byte_t CH_LA     = 8'h61;
  localparam byte_t CH_LF_HEX = 8'h66;

  localparam code_t EV_DATA     = 3'd0;
  localparam code_t EV_START    = 3'd1;
  localparam code_t EV_TERM     = 3'd2;
  localparam code_t EV_SUM_GOOD = 3'd3;
  localparam code_t EV_SUM_BAD  = 3'd4;
  localparam code_t EV_LINEFEED = 3'd5;

  localparam code_t KIND_UNKNOWN = 3'd0;
  localparam code_t KIND_GGA     = 3'd1;
  localparam code_t KIND_RMC     = 3'd2;
  localparam code_t KIND_GSA     = 3'd3;
  localparam code_t KIND_GSV     = 3'd4;

  // header text, first character in the low byte
  function automatic logic [8*HDR_LEN-1:0] header_text(input logic [1:0] k);
    logic [8*HDR_LEN-1:0] t;
    case (k)
      2'd0:    t = {"A", "G", "G", "P", "G", "$"};
      2'd1:    t = {"C", "M", "R", "P", "G", "$"};
      2'd2:    t = {"A", "S", "G", "P", "G", "$"};
      default: t = {"V", "S", "G", "P", "G", "$"};
    endcase
    return t;
  endfunction

  function automatic logic [3:0] hex_value(input byte_t c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[CH_0:CH_9]}) begin
      v = 4'(c - CH_0);
    end else if (c inside {[CH_UA:CH_UF]}) begin
      v = 4'(c - CH_UA + 8'd10);
    end else if (c inside {[CH_LA:CH_LF_HEX]}) begin
      v = 4'(c - CH_LA + 8'd10);
    end
    return v;
  endfunction

endpackage

// File: rtl/nmea_sentence_deframer.sv
// NMEA sentence deframer: one byte in, one event record out per byte.
// Depends on nmd_pkg (character codes, event codes, header text).
`timescale 1ns / 1ps
//
// Usage:
//   in_*   byte stream from the receiver UART, one character per request.
//   out_*  one record per input byte: event in out_tuser, the sentence
//          kind, term index, term length, echoed byte, running XOR and the
//          decoded received checksum in out_tdata.
//   Event codes: data char, sentence start, term closed, checksum good,
//   checksum bad, line feed. The checksum compare happens on every CR.
// Timing:
//   A byte taken into the input register is decoded from there and loaded into
//   the output register, and out_tvalid raised, once the output register is free
//   or being taken; while the receiver stalls, the byte waits in the input register.
//   One byte per cycle sustained while out_tready stays high; the term state is
//   updated in that single decode step.
// Reset clears the sentence state and both pipeline stages; no pass over
// storage is needed. When the receiver stalls, the result is held in the
// output register and the input register still takes one more byte, after
// which in_tready drops until out_tready returns.

module nmea_sentence_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [2:0] sentence_kind, [10:3] term_index,
                                  // [15:11] term_length, [23:16] data_char,
                                  // [31:24] sum_computed, [39:32] sum_received
  output logic [2:0]  out_tuser   // [2:0] event_res
);
  import nmd_pkg::*;

  logic        in_valid_r;
  byte_t       in_byte_r;
  logic        out_valid_r;
  logic [39:0] out_data_r, out_data_nxt;
  code_t       out_ev_r, out_ev_nxt;

  logic             star_r, star_nxt;
  byte_t            sum_r, sum_nxt;
  byte_t            tc_r, tc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  code_t            kind_r, kind_nxt;
  byte_t            chars_r [HDR_LEN];

  logic  adv, proc;
  byte_t c;
  byte_t recv;
  code_t match_kind;
  logic  do_store;

  assign adv       = !out_valid_r || out_tready;
  assign proc      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;
  assign c         = in_byte_r;

  always_comb begin
    logic [8*HDR_LEN-1:0] txt;
    logic                 same;
    match_kind = KIND_UNKNOWN;
    for (int k = NUM_HDR - 1; k >= 0; k--) begin
      txt  = header_text(2'(k));
      same = 1'b1;
      for (int i = 0; i < HDR_LEN; i++) begin
        if (chars_r[i] != txt[8*i +: 8]) same = 1'b0;
      end
      if (same) match_kind = 3'(k + 1);
    end
    if (pos_r < POS_W'(HDR_LEN)) match_kind = KIND_UNKNOWN;
  end

  always_comb begin
    byte_t d0, d1;
    d0 = (pos_r > POS_W'(0)) ? chars_r[0] : 8'd0;
    d1 = (pos_r > POS_W'(1)) ? chars_r[1] : 8'd0;
    recv = {hex_value(d0), hex_value(d1)};
  end

  always_comb begin
    star_nxt   = star_r;
    sum_nxt    = sum_r;
    tc_nxt     = tc_r;
    pos_nxt    = pos_r;
    kind_nxt   = kind_r;
    do_store   = 1'b0;
    out_ev_nxt = EV_DATA;
    case (c)
      CH_DOLLAR: begin
        star_nxt   = 1'b0;
        sum_nxt    = 8'd0;
        tc_nxt     = 8'd0;
        pos_nxt    = POS_W'(1);
        do_store   = 1'b1;
        out_ev_nxt = EV_START;
      end
      CH_COMMA, CH_STAR: begin
        if (c == CH_STAR) star_nxt = 1'b1;
        else if (!star_r) sum_nxt = sum_r ^ c;
        if (tc_r == 8'd0) kind_nxt = match_kind;
        tc_nxt     = tc_r + 8'd1;
        pos_nxt    = '0;
        out_ev_nxt = EV_TERM;
      end
      CH_CR: begin
        tc_nxt     = 8'd0;
        out_ev_nxt = (recv == sum_r) ? EV_SUM_GOOD : EV_SUM_BAD;
      end
      CH_LF: begin
        tc_nxt     = 8'd0;
        out_ev_nxt = EV_LINEFEED;
      end
      default: begin
        if (!star_r) sum_nxt = sum_r ^ c;
        if (pos_r < POS_W'(TERM_CAPACITY)) begin
          do_store = 1'b1;
          pos_nxt  = pos_r + POS_W'(1);
        end
      end
    endcase
    out_data_nxt = {(c == CH_CR) ? recv : 8'd0, sum_nxt, c,
                    5'(pos_nxt), tc_nxt, kind_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      star_r      <= 1'b0;
      sum_r       <= 8'd0;
      tc_r        <= 8'd0;
      pos_r       <= '0;
      kind_r      <= KIND_UNKNOWN;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (adv) out_valid_r <= in_valid_r;
      if (proc) begin
        star_r <= star_nxt;
        sum_r  <= sum_nxt;
        tc_r   <= tc_nxt;
        pos_r  <= pos_nxt;
        kind_r <= kind_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_byte_r <= in_tdata;
    if (proc) begin
      out_data_r <= out_data_nxt;
      out_ev_r   <= out_ev_nxt;
    end
    if (proc && do_store) begin
      for (int i = 0; i < HDR_LEN; i++) begin
        if ((c == CH_DOLLAR && i == 0) ||
            (c != CH_DOLLAR && pos_r == POS_W'(i))) begin
          chars_r[i] <= c;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ev_r;

  a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(TERM_CAPACITY))
    else $error("term length beyond capacity");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && c == CH_DOLLAR) |=> (sum_r == 8'd0 && tc_r == 8'd0 &&
                                  pos_r == POS_W'(1) && !star_r))
    else $error("sentence start did not clear state");

  a_kind_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(proc && (c == CH_COMMA || c == CH_STAR) && tc_r == 8'd0) |=> $stable(kind_r))
    else $error("sentence kind changed outside header close");

  a_line_end_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_ev_r == EV_START || out_ev_r == EV_LINEFEED ||
                     out_ev_r == EV_SUM_GOOD || out_ev_r == EV_SUM_BAD))
    |-> (out_data_r[10:3] == 8'd0))
    else $error("term index not zero at sentence boundary");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> !$past(proc))
    else $error("result overwritten while stalled");

endmodule

// File: test/tb_nmea_sentence_deframer.sv
// Testbench for nmea_sentence_deframer: directed and random NMEA byte streams,
// each byte's event record predicted in the bench and checked against out_*.
// Depends on nmd_pkg and rtl/nmea_sentence_deframer.sv.
`timescale 1ns / 1ps

module tb_nmea_sentence_deframer;
  import nmd_pkg::*;

  localparam int N_RANDOM = 1600;
  localparam int LIMIT    = 200000;

  typedef struct packed {
    code_t      ev;
    code_t      kind;
    logic [7:0] idx;
    logic [4:0] len;
    byte_t      ch;
    byte_t      sum;
    byte_t      recv;
  } rec_t;

  typedef struct {
    byte_t b;
    bit    drain;
  } req_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;

  nmea_sentence_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  req_t  byte_q[$];
  rec_t  record_q[$];
  int    n_err;
  int    n_acc;
  int    n_out;
  int    n_sentences;
  int    ev_cnt[6];
  int    cyc;
  logic  in_took;
  int    hold_left;
  bit    hold_done;
  logic  quiet;

  // deframer state as seen from outside
  bit         star_seen;
  byte_t      xor_sum;
  logic [7:0] term_no;
  logic [4:0] fill;
  byte_t      term_buf[TERM_CAPACITY];
  code_t      kind_now;

  assign quiet = (n_acc >= 300) && (n_acc < 600);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic byte_t char_at(int pos);
    if (pos < fill && pos < TERM_CAPACITY) return term_buf[pos];
    return 8'h00;
  endfunction

  function automatic logic [3:0] nibble_of(byte_t c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    return 4'd0;
  endfunction

  function automatic void keep_char(byte_t c);
    if (fill < TERM_CAPACITY) begin
      term_buf[fill] = c;
      fill++;
    end
  endfunction

  function automatic void end_term();
    logic [47:0] hdr;
    if (term_no == 0) begin
      hdr = {char_at(0), char_at(1), char_at(2), char_at(3), char_at(4), char_at(5)};
      kind_now = KIND_UNKNOWN;
      if (fill >= 6) begin
        case (hdr)
          "$GPGGA": kind_now = KIND_GGA;
          "$GPRMC": kind_now = KIND_RMC;
          "$GPGSA": kind_now = KIND_GSA;
          "$GPGSV": kind_now = KIND_GSV;
          default:  kind_now = KIND_UNKNOWN;
        endcase
      end
    end
    term_no++;
    fill = 5'd0;
  endfunction

  function automatic rec_t deframe_byte(byte_t c);
    rec_t r;
    r = '0;
    r.ev = EV_DATA;
    if (c == CH_DOLLAR) begin
      star_seen = 1'b0;
      xor_sum = 8'h00;
      term_no = 8'h00;
      fill = 5'd0;
      keep_char(c);
      r.ev = EV_START;
    end else if (c == CH_COMMA) begin
      if (!star_seen) xor_sum ^= c;
      end_term();
      r.ev = EV_TERM;
    end else if (c == CH_STAR) begin
      star_seen = 1'b1;
      end_term();
      r.ev = EV_TERM;
    end else if (c == CH_CR) begin
      r.recv = {nibble_of(char_at(0)), nibble_of(char_at(1))};
      r.ev = (r.recv == xor_sum) ? EV_SUM_GOOD : EV_SUM_BAD;
      term_no = 8'h00;
    end else if (c == CH_LF) begin
      term_no = 8'h00;
      r.ev = EV_LINEFEED;
    end else begin
      if (!star_seen) xor_sum ^= c;
      keep_char(c);
    end
    r.kind = kind_now;
    r.idx  = term_no;
    r.len  = fill;
    r.ch   = c;
    r.sum  = xor_sum;
    return r;
  endfunction

  task automatic put(byte_t b, bit mark = 1'b0);
    byte_q.push_back('{b, mark});
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  function automatic byte_t body_char();
    byte_t c;
    do begin
      if ($urandom_range(0, 99) < 70) c = byte_t'($urandom_range(8'h20, 8'h7E));
      else c = byte_t'($urandom_range(0, 255));
    end while (c == CH_DOLLAR || c == CH_COMMA || c == CH_STAR || c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function automatic byte_t hex_char(logic [3:0] n, bit lower);
    if (n < 10) return byte_t'("0" + n);
    return lower ? byte_t'("a" + n - 10) : byte_t'("A" + n - 10);
  endfunction

  // one sentence with random content; tail is a good, bad, short or missing checksum
  task automatic put_sentence(bit mark);
    string  names[4];
    byte_t  sum;
    byte_t  c;
    byte_t  sent;
    int     sel;
    int     len;
    int     tail;
    bit     lower;
    names = '{"GPGGA", "GPRMC", "GPGSA", "GPGSV"};
    sum = 8'h00;
    put(CH_DOLLAR, mark);
    sel = $urandom_range(0, 5);
    if (sel < 4) begin
      for (int i = 0; i < 5; i++) begin
        put(names[sel][i]);
        sum ^= byte_t'(names[sel][i]);
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 14) : 0;
    end else begin
      len = (sel == 4) ? 5 : $urandom_range(0, 4);
    end
    repeat (len) begin
      c = body_char();
      put(c);
      sum ^= c;
    end
    repeat ($urandom_range(0, 12)) begin
      put(CH_COMMA);
      sum ^= CH_COMMA;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 8);
      repeat (len) begin
        c = body_char();
        put(c);
        sum ^= c;
      end
    end
    tail  = $urandom_range(0, 99);
    lower = $urandom_range(0, 1);
    sent  = (tail < 70) ? sum : sum ^ byte_t'($urandom_range(1, 255));
    if (tail < 85) begin
      put(CH_STAR);
      if ($urandom_range(0, 19) == 0) put(body_char());
      else put(hex_char(sent[7:4], lower));
      put(hex_char(sent[3:0], lower));
    end else if (tail < 93) begin
      put(CH_STAR);
      put(hex_char(sent[3:0], lower));
    end
    put(CH_CR);
    if ($urandom_range(0, 9) != 0) put(CH_LF);
  endtask

  task automatic check(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_err++;
    end
  endtask

  // stimulus and end of run
  initial begin
    int k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    out_tready = 1'b0;
    in_took = 1'b0;
    n_err = 0;
    n_acc = 0;
    n_out = 0;
    n_sentences = 0;
    cyc = 0;
    hold_left = 0;
    hold_done = 1'b0;
    star_seen = 1'b0;
    xor_sum = 8'h00;
    term_no = 8'h00;
    fill = 5'd0;
    kind_now = KIND_UNKNOWN;
    foreach (term_buf[i]) term_buf[i] = 8'h00;
    foreach (ev_cnt[i]) ev_cnt[i] = 0;

    // directed: byte extremes, short checksum, header prefix, lowercase hex, bare CR
    put_text("$GPGGA,");
    put(8'hFF);
    put(8'h00);
    put_text("*7");
    put(CH_CR);
    put_text("$GPRMCX*ab");
    put(CH_CR);
    put(CH_DOLLAR);
    put(CH_CR);
    put(CH_LF);

    k = 0;
    while (byte_q.size() < N_RANDOM) begin
      if (k == 20) begin
        // term index wraps past 255
        put(CH_DOLLAR);
        repeat (300) put(CH_COMMA);
        put_text("*00");
        put(CH_CR);
        put(CH_LF);
        n_sentences++;
      end else if (k == 3 || k == 25 || $urandom_range(0, 99) < 80) begin
        put_sentence(k == 3 || k == 25);
        n_sentences++;
      end else begin
        repeat ($urandom_range(1, 8)) put(byte_t'($urandom_range(0, 255)));
      end
      k++;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (byte_q.size() == 0 && !in_tvalid);
    wait (record_q.size() == 0);
    repeat (16) @(posedge clk);

    $display("Checked %0d records from %0d sentences plus noise: %0d starts, %0d terms closed,",
             n_out, n_sentences, ev_cnt[EV_START], ev_cnt[EV_TERM]);
    $display("%0d good and %0d bad checksums, %0d line feeds; %0d mismatches.",
             ev_cnt[EV_SUM_GOOD], ev_cnt[EV_SUM_BAD], ev_cnt[EV_LINEFEED], n_err);
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // sender
  always @(negedge clk) begin : tx_side
    bit   go;
    req_t q;
    if (rst_n && (!in_tvalid || in_took)) begin
      go = 1'b0;
      if (byte_q.size() != 0) begin
        if (byte_q[0].drain) begin
          if (record_q.size() == 0) byte_q[0].drain = 1'b0;
        end else begin
          go = quiet || ($urandom_range(0, 99) >= 20);
        end
      end
      if (go) begin
        q = byte_q.pop_front();
        in_tdata <= q.b;
      end
      in_tvalid <= go;
    end
  end

  // receiver, with one long hold-off
  always @(negedge clk) begin : rx_side
    logic rdy;
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rdy = 1'b0;
      end else if (!hold_done && n_acc >= 800) begin
        hold_left <= 120;
        hold_done <= 1'b1;
        rdy = 1'b0;
      end else begin
        rdy = quiet || ($urandom_range(0, 99) >= 20);
      end
      out_tready <= rdy;
    end
  end

  // predict on each accepted byte, check each accepted record
  always @(posedge clk) begin : scoreboard
    rec_t e;
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      record_q.push_back(deframe_byte(in_tdata));
      n_acc++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      n_out++;
      if (out_tuser < 6) ev_cnt[out_tuser]++;
      if (record_q.size() == 0) begin
        $error("unexpected record, event %0d", out_tuser);
        n_err++;
      end else begin
        e = record_q.pop_front();
        check("event_res", e.ev, out_tuser);
        check("sentence_kind", e.kind, out_tdata[2:0]);
        check("term_index", e.idx, out_tdata[10:3]);
        check("term_length", e.len, out_tdata[15:11]);
        check("data_char", e.ch, out_tdata[23:16]);
        check("sum_computed", e.sum, out_tdata[31:24]);
        check("sum_received", e.recv, out_tdata[39:32]);
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
